// ----- hw/rtl/wts_pkg.sv -----
// wts_pkg: shared types, constants and helpers for the world_to_screen_project block.
// No dependencies.
package wts_pkg;

    localparam int unsigned NDC_W   = 49;  // ndc magnitude clamped to 2^47
    localparam int unsigned MAP_W   = 65;  // (ndc +/- one) times 14-bit size, zero-extended to 15 bits
    localparam int unsigned IN_W    = 136;
    localparam int unsigned OUT_W   = 96;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_POINT = 1'b1;

    localparam logic [1:0] REG_VP_WIDTH  = 2'd0;
    localparam logic [1:0] REG_VP_HEIGHT = 2'd1;

    typedef struct packed {
        logic               opcode;
        logic [3:0]         entry_index;
        logic signed [31:0] entry_value;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
    } entry_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] value;
    } sat_t;

    function automatic sat_t sat32(input logic signed [MAP_W-1:0] v);
        sat_t r;
        if (v > 65'sd2147483647) begin
            r.sat   = 1'b1;
            r.value = 32'sh7FFFFFFF;
        end else if (v < -65'sd2147483648) begin
            r.sat   = 1'b1;
            r.value = 32'sh80000000;
        end else begin
            r.sat   = 1'b0;
            r.value = v[31:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/wts_front.sv -----
// wts_front: accepts input words, decodes the opcode and queues them for the back end.
// Depends on wts_pkg.
module wts_front (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [wts_pkg::IN_W-1:0]     s_tdata,
    input  logic [0:0]                   s_tuser,
    output logic                         q_valid,
    input  logic                         q_pop,
    output wts_pkg::entry_t              q_entry
);

    localparam int unsigned DEPTH = 4;

    wts_pkg::entry_t fifo_reg [DEPTH];
    logic [1:0] head_reg, head_next;
    logic [1:0] tail_reg, tail_next;
    logic [2:0] count_reg, count_next;
    logic       push;
    logic       pop;
    wts_pkg::entry_t in_entry;

    always_comb begin
        in_entry.opcode      = s_tuser[0];
        in_entry.entry_index = s_tdata[3:0];
        in_entry.entry_value = s_tdata[35:4];
        in_entry.point_x     = s_tdata[67:36];
        in_entry.point_y     = s_tdata[99:68];
        in_entry.point_z     = s_tdata[131:100];
    end

    assign s_tready = (count_reg != 3'(DEPTH));
    assign q_valid  = (count_reg != 3'd0);
    assign q_entry  = fifo_reg[head_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_pop && q_valid;

    always_comb begin
        head_next  = pop  ? head_reg + 2'd1 : head_reg;
        tail_next  = push ? tail_reg + 2'd1 : tail_reg;
        count_next = count_reg + 3'(push) - 3'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            fifo_reg[tail_reg] <= in_entry;
        end
    end

endmodule

// ----- hw/rtl/wts_div.sv -----
// wts_div: three-lane restoring divider, one quotient bit per cycle, shared divisor.
// Gives clip / w with FRAC_BITS fraction bits, truncated, clamped to 2^47. Uses wts_pkg.
module wts_div #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               start,
    input  logic signed [66-FRAC_BITS:0]       num [3],
    input  logic signed [66-FRAC_BITS:0]       den,
    output logic                               done,
    output logic                               sat,
    output logic signed [wts_pkg::NDC_W-1:0]   quo [3]
);

    localparam int unsigned CW    = 67 - FRAC_BITS;
    localparam int unsigned QB    = 48;

    logic [CW-1:0]  ud_reg;
    logic [CW-1:0]  r_reg   [3];
    logic [QB-1:0]  lo_reg  [3];
    logic [QB-1:0]  q_reg   [3];
    logic [2:0]     ovf_reg;
    logic [2:0]     neg_reg;
    logic [5:0]     cnt_reg;
    logic           busy_reg;
    logic           done_reg;
    logic [CW-1:0]  ud;

    assign ud   = den[CW-1] ? CW'(-den) : CW'(den);
    assign done = done_reg;
    assign sat  = |ovf_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == 6'(QB - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
        logic [CW-1:0]    un;
        logic [66:0]      dext;
        logic [CW:0]      rs;
        logic             ge;

        assign un   = num[l][CW-1] ? CW'(-num[l]) : CW'(num[l]);
        assign dext = {un, FRAC_BITS'(0)};
        assign rs   = {r_reg[l], lo_reg[l][QB-1]};
        assign ge   = (rs >= {1'b0, ud_reg});

        always_ff @(posedge aclk) begin
            if (start) begin
                r_reg[l]   <= CW'(dext[66:QB]);
                lo_reg[l]  <= dext[QB-1:0];
                q_reg[l]   <= '0;
                ovf_reg[l] <= ((CW+QB)'(dext) >= (CW+QB)'({ud, (QB-1)'(0)}));
                neg_reg[l] <= num[l][CW-1] ^ den[CW-1];
            end else if (busy_reg) begin
                r_reg[l]  <= ge ? CW'(rs - {1'b0, ud_reg}) : CW'(rs);
                lo_reg[l] <= {lo_reg[l][QB-2:0], 1'b0};
                q_reg[l]  <= {q_reg[l][QB-2:0], ge};
            end
        end

        always_comb begin
            if (ovf_reg[l]) begin
                quo[l] = neg_reg[l] ? -(wts_pkg::NDC_W'(1) <<< 47) : (wts_pkg::NDC_W'(1) <<< 47);
            end else begin
                quo[l] = neg_reg[l] ? -$signed({1'b0, q_reg[l]}) : $signed({1'b0, q_reg[l]});
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ud_reg <= ud;
        end
    end

endmodule

// ----- hw/rtl/wts_back.sv -----
// wts_back: matrix store, row-at-a-time matrix multiply, divide, viewport map, output register.
// Depends on wts_pkg and wts_div.
module wts_back #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  wts_pkg::entry_t               q_entry,
    input  logic                          cfg_wr_en,
    input  logic [1:0]                    cfg_addr,
    input  logic [13:0]                   cfg_wdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [wts_pkg::OUT_W-1:0]     m_tdata,
    output logic [1:0]                    m_tuser
);

    localparam int unsigned CW = 67 - FRAC_BITS;
    localparam int unsigned NW = wts_pkg::NDC_W;
    localparam int unsigned MW = wts_pkg::MAP_W;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MUL  = 7'b0000010,
        ST_SUM  = 7'b0000100,
        ST_CHK  = 7'b0001000,
        ST_DIV  = 7'b0010000,
        ST_MAP  = 7'b0100000,
        ST_FIN  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [31:0]    mat_reg [16];
    logic [13:0]           vpw_reg;
    logic [13:0]           vph_reg;
    logic signed [31:0]    coord_reg [3];
    logic signed [63:0]    prod_reg [3];
    logic signed [CW-1:0]  clip_reg [4];
    logic [1:0]            row_reg;
    logic                  wz_reg;
    logic signed [MW-1:0]  mapx_reg;
    logic signed [MW-1:0]  mapy_reg;
    logic signed [NW-1:0]  nz_reg;
    logic                  dsat_reg;

    logic                  out_valid_reg;
    logic [95:0]           out_data_reg;
    logic [1:0]            out_user_reg;

    logic                  div_start;
    logic                  div_done;
    logic                  div_sat;
    logic signed [NW-1:0]  div_q [3];
    logic signed [CW-1:0]  div_num [3];

    logic signed [66:0]    acc;
    logic                  out_free;
    wts_pkg::sat_t         sx;
    wts_pkg::sat_t         sy;
    wts_pkg::sat_t         sz;
    logic signed [NW:0]    one_ext;

    assign div_num[0] = clip_reg[0];
    assign div_num[1] = clip_reg[1];
    assign div_num[2] = clip_reg[2];

    wts_div #(.FRAC_BITS(FRAC_BITS)) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (clip_reg[3]),
        .done    (div_done),
        .sat     (div_sat),
        .quo     (div_q)
    );

    assign out_free  = !out_valid_reg || m_tready;
    assign q_pop     = (state_reg == ST_IDLE) && q_valid;
    assign div_start = (state_reg == ST_CHK) && (clip_reg[3] != '0);
    assign one_ext   = (NW+1)'(1) <<< FRAC_BITS;

    assign acc = 67'(prod_reg[0]) + 67'(prod_reg[1]) + 67'(prod_reg[2])
               + (67'(mat_reg[{row_reg, 2'd3}]) <<< FRAC_BITS);

    assign sx = wts_pkg::sat32(mapx_reg >>> 1);
    assign sy = wts_pkg::sat32(mapy_reg >>> 1);
    assign sz = wts_pkg::sat32(MW'(nz_reg));

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (q_valid && q_entry.opcode == wts_pkg::OP_POINT) state_next = ST_MUL;
            ST_MUL:  state_next = ST_SUM;
            ST_SUM:  state_next = (row_reg == 2'd3) ? ST_CHK : ST_MUL;
            ST_CHK:  state_next = (clip_reg[3] == '0) ? ST_FIN : ST_DIV;
            ST_DIV:  if (div_done) state_next = ST_MAP;
            ST_MAP:  state_next = ST_FIN;
            ST_FIN:  if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            vpw_reg       <= 14'd1024;
            vph_reg       <= 14'd768;
            for (int i = 0; i < 16; i++) begin
                mat_reg[i] <= (i % 5 == 0) ? (32'sd1 <<< FRAC_BITS) : 32'sd0;
            end
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en && cfg_addr == wts_pkg::REG_VP_WIDTH)  vpw_reg <= cfg_wdata;
            if (cfg_wr_en && cfg_addr == wts_pkg::REG_VP_HEIGHT) vph_reg <= cfg_wdata;
            if (q_pop && q_entry.opcode == wts_pkg::OP_LOAD) begin
                mat_reg[q_entry.entry_index] <= q_entry.entry_value;
            end
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                coord_reg[0] <= q_entry.point_x;
                coord_reg[1] <= q_entry.point_y;
                coord_reg[2] <= q_entry.point_z;
                row_reg      <= 2'd0;
            end
            ST_MUL: begin
                for (int c = 0; c < 3; c++) begin
                    prod_reg[c] <= 64'(mat_reg[{row_reg, 2'(c)}]) * 64'(coord_reg[c]);
                end
            end
            ST_SUM: begin
                clip_reg[row_reg] <= acc[66:FRAC_BITS];
                row_reg           <= row_reg + 2'd1;
            end
            ST_CHK: begin
                wz_reg <= (clip_reg[3] == '0);
            end
            ST_MAP: begin
                mapx_reg <= MW'((NW+1)'(div_q[0]) + one_ext) * $signed({1'b0, vpw_reg});
                mapy_reg <= MW'(one_ext - (NW+1)'(div_q[1])) * $signed({1'b0, vph_reg});
                nz_reg   <= div_q[2];
                dsat_reg <= div_sat;
            end
            ST_FIN: begin
                if (out_free) begin
                    if (wz_reg) begin
                        out_data_reg <= '0;
                        out_user_reg <= 2'b01;
                    end else begin
                        out_data_reg <= {sz.value, sy.value, sx.value};
                        out_user_reg <= {dsat_reg | sx.sat | sy.sat | sz.sat, 1'b0};
                    end
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

endmodule

// ----- hw/rtl/world_to_screen_project.sv -----
// world_to_screen_project: top level of the world-to-screen projection block.
// Depends on wts_pkg, wts_front, wts_back (and wts_div below it).
//
// Input stream s_*: one word per item. s_tuser[0] is the opcode: 0 loads matrix
// entry entry_index (row*4+col) with entry_value, 1 projects point (x,y,z).
// Result stream m_*: one word per point, none per load.
// Config port: cfg_wr_en/cfg_addr/cfg_wdata; address 0 viewport width,
// address 1 viewport height; other addresses are ignored.
// Order of work: a load is written into the matrix as the idle back end pops it
// from the queue. A point passes the queue, the row-at-a-time multiply (a
// multiply and a sum state per row), the w check, the 48-step bit-serial divider,
// the map and the output register; with zero w the divider and map are skipped.
// The back end finishes a point before it takes the next item; loads go one per cycle while it is idle.
// A 4-word queue lets input words be taken while the back end is busy.
// Reset (aresetn low, synchronous) empties the queue, drops any pending
// result, loads the identity matrix and sets the viewport to 1024 x 768.
// When m_tready is low the result holds in the output register; the back end
// then stops before its next result and the queue fills, lowering s_tready.
module world_to_screen_project #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [135:0]  s_tdata,   // entry_index, entry_value, point_x, point_y, point_z
    input  logic [0:0]    s_tuser,   // opcode
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,   // screen_x, screen_y, depth_ndc
    output logic [1:0]    m_tuser,   // w_zero, saturated
    input  logic          cfg_wr_en,
    input  logic [1:0]    cfg_addr,
    input  logic [13:0]   cfg_wdata
);

    logic            q_valid;
    logic            q_pop;
    wts_pkg::entry_t q_entry;

    wts_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_entry  (q_entry)
    );

    wts_back #(.FRAC_BITS(FRAC_BITS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_entry   (q_entry),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

endmodule
